FILE: rtl/bti_pkg.sv
// bti_pkg: shared types, codes and helpers of the breakpoint table interpolator
// no dependencies; imported by bti_cell, bti_muldiv, breakpoint_table_interpolator and tb
package bti_pkg;

  localparam logic [1:0] MODE_LINEAR   = 2'd0;
  localparam logic [1:0] MODE_NEAREST  = 2'd1;
  localparam logic [1:0] MODE_PREVIOUS = 2'd2;
  localparam logic [1:0] MODE_NEXT     = 2'd3;

  localparam logic [1:0] REG_INTERP_MODE = 2'd0;
  localparam logic [1:0] REG_FILL_ENABLE = 2'd1;
  localparam logic [1:0] REG_FILL_VALUE  = 2'd2;
  localparam logic [1:0] REG_POINT_COUNT = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  localparam int PROD_W = 66;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MATH,
    ST_DONE
  } top_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

  // token that walks the row of cells
  typedef struct packed {
    logic               pass2;
    logic signed [31:0] q;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } tok_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi_lim;
    logic signed [67:0] lo_lim;
    hi_lim = 68'sd2147483647;
    lo_lim = -68'sd2147483648;
    if (v > hi_lim) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo_lim) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (33'd0 - v) : v;
  endfunction

endpackage

FILE: rtl/breakpoint_table_interpolator.sv
// breakpoint_table_interpolator: top level, row of breakpoint cells plus muldiv unit
// depends on bti_pkg, bti_cell, bti_muldiv
//
// Input channel (in_valid_i/in_ready_o) carries load and query transactions.
// A load writes one breakpoint into its cell in the accept cycle and gives no
// result. A query sends a token twice along the row of MAX_POINTS cells: the
// first pass counts breakpoints at or below the query and picks up the range
// ends, the second collects the bracketing pair. Linear mode then runs the
// shared multiply/divide unit, shift-add multiply followed by restoring division,
// unless the query is out of range or the pair has equal x. One query is in
// flight at a time, and loads are accepted only while the block is idle.
// Results sit in an output register (out_valid_o/out_ready_i); the next
// transaction is accepted while a result waits, and a finished query holds
// until the register is free. Reset clears control state and configuration
// registers; table entries are undefined until loaded.
module breakpoint_table_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [5:0]         point_index_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] query_x_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               status_o
);
  import bti_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [1:0]         mode_q;
  logic               fill_en_q;
  logic signed [31:0] fill_val_q;
  logic [6:0]         pcount_q;

  top_state_e         state_q, state_d;
  tok_t               res_q;
  logic               out_valid_q;
  logic signed [31:0] value_q;
  logic               status_q;

  logic               tap_v   [MAX_POINTS+1];
  tok_t               tap_tok [MAX_POINTS+1];
  logic [CNT_W-1:0]   tap_cnt [MAX_POINTS+1];

  logic               in_acc;
  logic               q_acc;
  logic               wr_en;
  tok_t               last_tok;
  logic               last_v;
  logic               wrap;
  logic               fin;
  logic [31:0]        n_w;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   nm1;
  logic [CNT_W-1:0]   nm2;
  logic [CNT_W-1:0]   bidx;
  tok_t               fresh;
  tok_t               wrap_tok;
  logic               last_oor;
  logic               need_div;
  logic signed [32:0] md_a, md_b, md_d;
  logic               md_done;
  logic signed [66:0] quot;
  logic               out_load;
  logic signed [31:0] res_value;
  logic               res_status;
  logic signed [32:0] dl, dr;
  logic signed [67:0] lin_sum;
  logic               res_oor;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_LINEAR;
      fill_en_q  <= 1'b0;
      fill_val_q <= '0;
      pcount_q   <= 7'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INTERP_MODE: mode_q     <= cfg_data_i[1:0];
        REG_FILL_ENABLE: fill_en_q  <= cfg_data_i[0];
        REG_FILL_VALUE:  fill_val_q <= cfg_data_i;
        REG_POINT_COUNT: pcount_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pcount_q < 7'd2) begin
      n_w = 32'd2;
    end else if (32'(pcount_q) > 32'(MAX_POINTS)) begin
      n_w = 32'(MAX_POINTS);
    end else begin
      n_w = 32'(pcount_q);
    end
  end
  assign n   = n_w[CNT_W-1:0];
  assign nm1 = n - CNT_W'(1);
  assign nm2 = n - CNT_W'(2);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign q_acc      = in_acc && (action_i == ACT_QUERY);
  assign wr_en      = in_acc && (action_i == ACT_LOAD);

  assign last_v   = tap_v[MAX_POINTS];
  assign last_tok = tap_tok[MAX_POINTS];
  assign wrap     = last_v && !last_tok.pass2;
  assign fin      = last_v && last_tok.pass2;

  // bracket index: last entry at or below the query, kept inside the table
  always_comb begin
    if (tap_cnt[MAX_POINTS] == '0) begin
      bidx = '0;
    end else begin
      bidx = tap_cnt[MAX_POINTS] - CNT_W'(1);
    end
    if (bidx > nm2) begin
      bidx = nm2;
    end
  end

  always_comb begin
    fresh       = '0;
    fresh.q     = query_x_i;
    wrap_tok    = last_tok;
    wrap_tok.pass2 = 1'b1;
  end

  assign tap_v[0]   = q_acc || wrap;
  assign tap_tok[0] = wrap ? wrap_tok : fresh;
  assign tap_cnt[0] = wrap ? bidx : '0;

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    bti_cell #(
      .INDEX (j),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_valid_i (tap_v[j]),
      .tok_i       (tap_tok[j]),
      .cnt_i       (tap_cnt[j]),
      .nm1_i       (nm1),
      .wr_en_i     (wr_en),
      .wr_idx_i    (point_index_i),
      .wr_x_i      (point_x_i),
      .wr_y_i      (point_y_i),
      .tok_valid_o (tap_v[j+1]),
      .tok_o       (tap_tok[j+1]),
      .cnt_o       (tap_cnt[j+1])
    );
  end

  assign last_oor = (last_tok.q < last_tok.lo) || (last_tok.q > last_tok.hi);
  assign need_div = fin && (mode_q == MODE_LINEAR) && !last_oor
                    && (last_tok.x1 != last_tok.x0);

  assign md_a = {last_tok.q[31], last_tok.q} - {last_tok.x0[31], last_tok.x0};
  assign md_b = {last_tok.y1[31], last_tok.y1} - {last_tok.y0[31], last_tok.y0};
  assign md_d = {last_tok.x1[31], last_tok.x1} - {last_tok.x0[31], last_tok.x0};

  bti_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (need_div),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .quot_o  (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_acc) state_d = ST_SCAN;
      ST_SCAN: if (fin) state_d = need_div ? ST_MATH : ST_DONE;
      ST_MATH: if (md_done) state_d = ST_DONE;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_q <= last_tok;
    end
    if (out_load) begin
      value_q  <= res_value;
      status_q <= res_status;
    end
  end

  // result select
  assign res_oor = (res_q.q < res_q.lo) || (res_q.q > res_q.hi);
  assign dl      = {res_q.q[31], res_q.q} - {res_q.x0[31], res_q.x0};
  assign dr      = {res_q.x1[31], res_q.x1} - {res_q.q[31], res_q.q};
  assign lin_sum = {{36{res_q.y0[31]}}, res_q.y0} + {quot[66], quot};

  always_comb begin
    res_status = STATUS_OK;
    res_value  = res_q.y0;
    if (res_oor) begin
      if (fill_en_q) begin
        res_value = fill_val_q;
      end else begin
        res_value  = '0;
        res_status = STATUS_OOR;
      end
    end else begin
      case (mode_q)
        MODE_LINEAR: begin
          if (res_q.x1 != res_q.x0) begin
            res_value = sat32(lin_sum);
          end
        end
        MODE_NEAREST: begin
          if (!(dl <= dr)) begin
            res_value = res_q.y1;
          end
        end
        MODE_PREVIOUS: res_value = res_q.y0;
        MODE_NEXT: begin
          if (res_q.q != res_q.x0) begin
            res_value = res_q.y1;
          end
        end
        default: res_value = res_q.y0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

FILE: rtl/bti_cell.sv
// bti_cell: one breakpoint of the table plus one stage of the search token
// depends on bti_pkg
module bti_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  bti_pkg::tok_t    tok_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [CNT_W-1:0] nm1_i,
  input  logic             wr_en_i,
  input  logic [5:0]       wr_idx_i,
  input  logic [31:0]      wr_x_i,
  input  logic [31:0]      wr_y_i,
  output logic             tok_valid_o,
  output bti_pkg::tok_t    tok_o,
  output logic [CNT_W-1:0] cnt_o
);
  import bti_pkg::*;

  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic               valid_q;
  tok_t               tok_q, tok_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   my_idx;

  assign my_idx = CNT_W'(INDEX);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_idx_i) == 32'(INDEX))) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    cnt_d = cnt_i;
    if (!tok_i.pass2) begin
      // first pass: count entries in use at or below the query, pick up range ends
      if ((my_idx <= nm1_i) && (x_q <= tok_i.q)) begin
        cnt_d = cnt_i + CNT_W'(1);
      end
      if (my_idx == '0) begin
        tok_d.lo = x_q;
      end
      if (my_idx == nm1_i) begin
        tok_d.hi = x_q;
      end
    end else begin
      // second pass: cnt carries the bracket index
      if (my_idx == cnt_i) begin
        tok_d.x0 = x_q;
        tok_d.y0 = y_q;
      end
      if (my_idx == cnt_i + CNT_W'(1)) begin
        tok_d.x1 = x_q;
        tok_d.y1 = y_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    cnt_q <= cnt_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;
  assign cnt_o       = cnt_q;

endmodule

FILE: rtl/bti_muldiv.sv
// bti_muldiv: sequential signed trunc(a*b/d), shift-add multiply then restoring divide
// depends on bti_pkg
module bti_muldiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  input  logic signed [32:0] d_i,
  output logic               done_o,
  output logic signed [66:0] quot_o
);
  import bti_pkg::*;

  md_phase_e          phase_q, phase_d;
  logic [6:0]         cnt_q;
  logic [PROD_W-1:0]  mcand_q;
  logic [32:0]        mplier_q;
  logic [PROD_W-1:0]  acc_q;
  logic [PROD_W-1:0]  dq_q;
  logic [32:0]        rem_q;
  logic [32:0]        md_q;
  logic               neg_q;
  logic               done_q;
  logic [PROD_W-1:0]  acc_next;
  logic [33:0]        r2;
  logic               qb;
  logic               mul_last;
  logic               div_last;

  assign acc_next = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
  assign r2       = {rem_q, dq_q[PROD_W-1]};
  assign qb       = (r2 >= {1'b0, md_q});
  assign mul_last = (cnt_q == 7'd32);
  assign div_last = (cnt_q == 7'(PROD_W - 1));

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      MD_IDLE: if (start_i) phase_d = MD_MUL;
      MD_MUL:  if (mul_last) phase_d = MD_DIV;
      MD_DIV:  if (div_last) phase_d = MD_IDLE;
      default: phase_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == MD_DIV) && div_last;
      if (phase_q != phase_d) begin
        cnt_q <= '0;
      end else if (phase_q != MD_IDLE) begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          mcand_q  <= PROD_W'(mag33(a_i));
          mplier_q <= mag33(b_i);
          md_q     <= mag33(d_i);
          neg_q    <= (a_i[32] ^ b_i[32]) ^ d_i[32];
          acc_q    <= '0;
        end
      end
      MD_MUL: begin
        acc_q    <= acc_next;
        mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[32:1]};
        if (mul_last) begin
          dq_q  <= acc_next;
          rem_q <= '0;
        end
      end
      MD_DIV: begin
        // quotient bits shift in behind the dividend
        rem_q <= qb ? 33'(r2 - {1'b0, md_q}) : r2[32:0];
        dq_q  <= {dq_q[PROD_W-2:0], qb};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (67'sd0 - $signed({1'b0, dq_q})) : $signed({1'b0, dq_q});

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for breakpoint_table_interpolator
// depends on bti_pkg and the block's rtl; a scoreboard class predicts every query result
module tb;
  import bti_pkg::*;

  localparam int  NPTS      = 64;
  localparam int  SETTLE    = 300;
  localparam int  RAND_ITEMS = 1100;
  localparam longint LIMIT  = 4000000;

  typedef struct {
    logic signed [31:0] value;
    logic               status;
  } lookup_res_t;

  class lookup_board;
    logic signed [31:0] bx [NPTS];
    logic signed [31:0] by [NPTS];
    logic [1:0]         mode;
    logic               fill_en;
    logic signed [31:0] fill_val;
    logic [6:0]         count;
    lookup_res_t        pend [$];
    int                 errors;
    int                 checked;

    function new();
      mode = MODE_LINEAR;
      fill_en = 1'b0;
      fill_val = '0;
      count = 7'd2;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_INTERP_MODE: mode = data[1:0];
        REG_FILL_ENABLE: fill_en = data[0];
        REG_FILL_VALUE:  fill_val = data;
        default:         count = data[6:0];
      endcase
    endfunction

    // called for every accepted transaction
    function void note_input(logic act, logic [5:0] idx, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] qx);
      int n, cnt, i;
      longint q, x0, x1, y0, y1;
      logic signed [127:0] prod, sum;
      lookup_res_t r;
      if (act == ACT_LOAD) begin
        bx[idx] = px;
        by[idx] = py;
        return;
      end
      n = count < 2 ? 2 : (count > NPTS ? NPTS : count);
      q = qx;
      r.status = STATUS_OK;
      if (q < longint'(bx[0]) || q > longint'(bx[n-1])) begin
        if (fill_en) r.value = fill_val;
        else begin
          r.value = '0;
          r.status = STATUS_OOR;
        end
      end else begin
        cnt = 0;
        for (int j = 0; j < n; j++) if (longint'(bx[j]) <= q) cnt++;
        i = cnt == 0 ? 0 : cnt - 1;
        if (i > n - 2) i = n - 2;
        x0 = bx[i]; x1 = bx[i+1]; y0 = by[i]; y1 = by[i+1];
        case (mode)
          MODE_LINEAR: begin
            if (x1 == x0) r.value = 32'(y0);
            else begin
              prod = 128'(q - x0) * 128'(y1 - y0);
              sum = 128'(y0) + prod / 128'(x1 - x0);
              if (sum > 128'sd2147483647) r.value = 32'sh7fffffff;
              else if (sum < -128'sd2147483648) r.value = 32'sh80000000;
              else r.value = sum[31:0];
            end
          end
          MODE_NEAREST:  r.value = 32'((q - x0 <= x1 - q) ? y0 : y1);
          MODE_PREVIOUS: r.value = 32'(y0);
          default:       r.value = 32'((q == x0) ? y0 : y1);
        endcase
      end
      pend.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] v, logic s);
      lookup_res_t e;
      checked++;
      if (pend.size() == 0) begin
        errors++;
        $display("%0t unexpected result value %h status %0d", $time, v, s);
        return;
      end
      e = pend.pop_front();
      if (v !== e.value) begin
        errors++;
        $display("%0t value mismatch expected %h actual %h", $time, e.value, v);
      end
      if (s !== e.status) begin
        errors++;
        $display("%0t status mismatch expected %0d actual %0d", $time, e.status, s);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               action_i = 1'b0;
  logic [5:0]         point_index_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [31:0] query_x_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic               status_o;

  breakpoint_table_interpolator i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lookup_board sb = new();
  longint cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int stall_left = 0;
  int queries = 0;
  int items = 0;
  int phases = 0;
  logic signed [31:0] tx [NPTS];
  logic signed [31:0] ty [NPTS];

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver backpressure: mostly ready, short stalls, a few long ones
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (rx_calm) out_ready_i <= 1'b1;
    else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (r < 3) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(10, 80);
    end else out_ready_i <= (r >= 20);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(value_o, status_o);
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called at a rising edge; returns at the edge that takes the transaction, or after a random gap with valid low
  task automatic send(logic act, logic [5:0] idx, logic [31:0] px, logic [31:0] py,
                      logic [31:0] qx);
    int g;
    in_valid_i <= 1'b1;
    action_i <= act;
    point_index_i <= idx;
    point_x_i <= px;
    point_y_i <= py;
    query_x_i <= qx;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_input(act, idx, px, py, qx);
    items++;
    if (act == ACT_QUERY) queries++;
    @(posedge clk_i);
    g = rand_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic load(int idx, logic [31:0] px, logic [31:0] py);
    tx[idx] = px;
    ty[idx] = py;
    send(ACT_LOAD, idx[5:0], px, py, $urandom);
  endtask

  task automatic query(logic [31:0] qx);
    send(ACT_QUERY, 6'($urandom), $urandom, $urandom, qx);
  endtask

  // wait for every result, let the block settle, then write all registers
  task automatic configure(logic [1:0] md, logic fe, logic [31:0] fv, logic [6:0] pc);
    in_valid_i <= 1'b0;
    while (sb.pend.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_INTERP_MODE; cfg_data_i <= {30'($urandom), md};
    sb.set_reg(REG_INTERP_MODE, {30'd0, md});
    @(posedge clk_i);
    cfg_idx_i <= REG_FILL_ENABLE; cfg_data_i <= {31'($urandom), fe};
    sb.set_reg(REG_FILL_ENABLE, {31'd0, fe});
    @(posedge clk_i);
    cfg_idx_i <= REG_FILL_VALUE; cfg_data_i <= fv;
    sb.set_reg(REG_FILL_VALUE, fv);
    @(posedge clk_i);
    cfg_idx_i <= REG_POINT_COUNT; cfg_data_i <= {25'($urandom), pc};
    sb.set_reg(REG_POINT_COUNT, {25'd0, pc});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_data_i <= $urandom;
    @(posedge clk_i);
    phases++;
  endtask

  // kind 0 increasing, 1 increasing with tiny steps, 2 repeated x, 3 unordered
  task automatic load_table(int n, int kind);
    longint x;
    int step;
    x = -64'sd2147483648 + $urandom_range(0, 32'h3fffffff);
    if (kind == 1) x = $signed($urandom);
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: step = $urandom_range(1, 32'h01ffffff);
        1: step = $urandom_range(1, 3);
        2: step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32'h01ffffff);
        default: step = 0;
      endcase
      if (k > 0) x = x + step;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      load(k, (kind == 3) ? $urandom : x[31:0], $urandom);
    end
  endtask

  task automatic rand_query(int n);
    longint lo, hi, span, q;
    int r, k;
    lo = tx[0]; hi = tx[n-1];
    if (lo > hi) begin q = lo; lo = hi; hi = q; end
    span = hi - lo + 1;
    k = $urandom_range(0, n - 1);
    r = $urandom_range(0, 99);
    if (r < 60) q = lo + longint'({$urandom, $urandom} % span);
    else if (r < 75) q = tx[k];
    else if (r < 82) q = longint'(tx[k]) + (($urandom_range(0, 1) == 1) ? 1 : -1);
    else if (r < 90) q = ($urandom_range(0, 1) == 1) ? longint'(tx[0]) - 1
                                                        : longint'(tx[n-1]) + 1;
    else q = $signed($urandom);
    query(q[31:0]);
  endtask

  initial begin
    int n, kind, r, nq;
    logic [6:0] pc;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry gets written before any query can read it
    load_table(NPTS, 0);

    // directed: range extremes and repeated x
    load(0, 32'h80000000, 32'h7fffffff);
    load(1, 32'h00000000, 32'h80000000);
    load(2, 32'h00000000, 32'h00000005);
    load(3, 32'h7fffffff, 32'h7fffffff);
    for (int m = 0; m < 4; m++) begin
      configure(m[1:0], 1'b0, 32'h0, 7'd4);
      query(32'h80000000);
      query(32'hffffffff);
      query(32'h00000000);
      query(32'h7fffffff);
    end
    configure(MODE_LINEAR, 1'b1, 32'h80000000, 7'd3);
    query(32'h00000001);
    configure(MODE_NEAREST, 1'b0, 32'h7fffffff, 7'd3);
    query(32'h7fffffff);

    // random phases; the drain in configure also holds the sender off
    while (items < RAND_ITEMS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) pc = 7'($urandom_range(2, 8));
      else if (r < 80) pc = 7'($urandom_range(9, 20));
      else if (r < 90) pc = 7'(NPTS);
      else if (r < 95) pc = 7'($urandom_range(0, 1));
      else pc = 7'($urandom_range(NPTS + 1, 127));
      r = $urandom_range(0, 9);
      configure(2'($urandom), (r < 5), (r == 9) ? 32'h7fffffff : $urandom, pc);
      n = pc < 2 ? 2 : (pc > NPTS ? NPTS : pc);
      r = $urandom_range(0, 99);
      kind = r < 70 ? 0 : (r < 80 ? 1 : (r < 90 ? 2 : 3));
      load_table(n, kind);
      nq = $urandom_range(10, 30);
      for (int k = 0; k < nq; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          r = $urandom_range(0, n - 1);
          load(r, ($urandom_range(0, 1) == 1) ? tx[r] : $urandom, $urandom);
        end
        rand_query(n);
      end
    end

    in_valid_i <= 1'b0;
    rx_calm = 1'b1;
    while (sb.pend.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("ran %0d transactions (%0d queries) over %0d register settings, %0d results checked",
             items, queries, phases, sb.checked);
    $display("covered all four modes, fill on and off, point counts 0 to 127");
    if (sb.errors == 0 && sb.pend.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
